// ===== design/line_follow_pid_steering_unit_defines.svh =====
// Assertion macros used by the checker file of the steering unit.
`ifndef LINE_FOLLOW_PID_STEERING_UNIT_DEFINES_SVH
`define LINE_FOLLOW_PID_STEERING_UNIT_DEFINES_SVH

// Same-cycle implication, switched off while reset is held.
`define LFPS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define LFPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked during reset.
`define LFPS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/lfps_pkg.sv =====
package lfps_pkg;

    // Width of the signed error accumulator.
    localparam int SUM_WIDTH = 24;

    localparam int GAIN_W  = 16;
    localparam int LEVEL_W = 7;
    localparam int ERR_W   = 8;
    localparam int DELTA_W = 9;
    localparam int PWM_W   = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // The Q8.8 gains and the 4 ms tick fold into N / 128000, with
    // N = 500*kp*e + ki*acc + 125000*kd*(e - e_prev).
    localparam longint KP_SCALE = 500;
    localparam longint KD_SCALE = 125000;
    localparam longint GAIN_MAX = (longint'(1) << GAIN_W) - 1;
    localparam int KP_S_W = $clog2(GAIN_MAX * KP_SCALE + 1);
    localparam int KD_S_W = $clog2(GAIN_MAX * KD_SCALE + 1);

    // Signed product widths of the three terms and of their sum.
    localparam int PKP_W = KP_S_W + 1 + ERR_W;
    localparam int PKI_W = GAIN_W + 1 + SUM_WIDTH;
    localparam int PKD_W = KD_S_W + 1 + DELTA_W;
    localparam int PMAX_W = (PKP_W > PKI_W) ?
                            ((PKP_W > PKD_W) ? PKP_W : PKD_W) :
                            ((PKI_W > PKD_W) ? PKI_W : PKD_W);
    localparam int NUM_W = PMAX_W + 2;

    // 128000 = 2^10 * 125. Magnitudes at or above 256 * 128000 saturate the steered
    // motor anyway, so the quotient is only needed below that.
    localparam int     DIV_SHIFT = 10;
    localparam longint DIV_ODD   = 125;
    localparam longint Q_LIMIT   = 256;
    localparam longint MAG_LIMIT = Q_LIMIT * DIV_ODD * (longint'(1) << DIV_SHIFT);
    localparam int     X_W       = $clog2(MAG_LIMIT >> DIV_SHIFT);

    // floor(x / 125) = (x * 33555) >> 22 holds exactly for every x below 2^15.
    localparam int                RECIP_W     = 16;
    localparam logic [RECIP_W-1:0] RECIP_MUL  = RECIP_W'(33555);
    localparam int                RECIP_SHIFT = 22;
    localparam int                Q_W         = 9;
    localparam int                SPEED_W     = Q_W + 1;
    localparam int                MOTOR_W     = SPEED_W + 1;

    localparam int DUTY_LIMIT = 100;

    // Register reset values.
    localparam longint KP_RESET       = 179;
    localparam longint KI_RESET       = 77;
    localparam longint KD_RESET       = 8;
    localparam int     SETPOINT_RESET = 11;
    localparam int     BASE_RESET     = 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP       = 3'd0,
        CFG_KI       = 3'd1,
        CFG_KD       = 3'd2,
        CFG_SETPOINT = 3'd3,
        CFG_BASE     = 3'd4
    } t_cfg_idx;

endpackage

// ===== design/lfps_if.sv =====
// Brightness samples into the unit.
interface lfps_in_if;
    logic                        valid;
    logic                        ready;
    logic [lfps_pkg::LEVEL_W-1:0] brightness;

    modport source (output valid, output brightness, input ready);
    modport sink   (input valid, input brightness, output ready);
endinterface

// Motor duty results out of the unit.
interface lfps_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [lfps_pkg::PWM_W-1:0] right_pwm;
    logic signed [lfps_pkg::PWM_W-1:0] left_pwm;

    modport source (output valid, output right_pwm, output left_pwm, input ready);
    modport sink   (input valid, input right_pwm, input left_pwm, output ready);
endinterface

// Register writes.
interface lfps_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [lfps_pkg::CFG_IDX_W-1:0]  index;
    logic [lfps_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/line_follow_pid_steering_unit.sv =====
// PID steering unit for a line-following robot. Each input beat carries one
// reflected-light sample; each output beat carries the right and left motor
// duties (signed percent, saturated to -100..100) that the sample produces,
// one result per sample, in order. The unit is a four-stage pipeline
// (error and accumulator update, gain products, sum and scaling, reciprocal
// divide and motor mix). A result is offered once its sample has passed the
// stage A, B, C and D registers; a new sample is taken every cycle while the
// output side is ready. The one loop that limits the rate is the
// error/accumulator update in the first stage, which closes within that stage.
// Stages that hold a bubble let the input keep moving while a finished result
// waits on the output. Register writes (gains, setpoint, base power)
// are taken in any cycle and must only be issued while no sample is in
// flight; writes to unused indexes are dropped.
module line_follow_pid_steering_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lfps_cfg_if.sink      i_cfg,
    lfps_in_if.sink       i_in,
    lfps_out_if.source    o_out
);

    // ------------------------------------------------------------------
    // Configuration registers. The proportional and derivative gains are
    // stored pre-multiplied by their tick scale factors so that each term
    // of the control law costs a single multiply in the datapath.
    // ------------------------------------------------------------------
    logic [lfps_pkg::KP_S_W-1:0]  r_kp_s;
    logic [lfps_pkg::GAIN_W-1:0]  r_ki;
    logic [lfps_pkg::KD_S_W-1:0]  r_kd_s;
    logic [lfps_pkg::LEVEL_W-1:0] r_setpoint;
    logic [lfps_pkg::LEVEL_W-1:0] r_base;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp_s     <= lfps_pkg::KP_S_W'(lfps_pkg::KP_RESET * lfps_pkg::KP_SCALE);
            r_ki       <= lfps_pkg::GAIN_W'(lfps_pkg::KI_RESET);
            r_kd_s     <= lfps_pkg::KD_S_W'(lfps_pkg::KD_RESET * lfps_pkg::KD_SCALE);
            r_setpoint <= lfps_pkg::LEVEL_W'(lfps_pkg::SETPOINT_RESET);
            r_base     <= lfps_pkg::LEVEL_W'(lfps_pkg::BASE_RESET);
        end else if (i_cfg.valid) begin
            case (lfps_pkg::t_cfg_idx'(i_cfg.index))
                lfps_pkg::CFG_KP: begin
                    r_kp_s <= lfps_pkg::KP_S_W'(i_cfg.data) *
                              lfps_pkg::KP_S_W'(lfps_pkg::KP_SCALE);
                end
                lfps_pkg::CFG_KI: begin
                    r_ki <= i_cfg.data;
                end
                lfps_pkg::CFG_KD: begin
                    r_kd_s <= lfps_pkg::KD_S_W'(i_cfg.data) *
                              lfps_pkg::KD_S_W'(lfps_pkg::KD_SCALE);
                end
                lfps_pkg::CFG_SETPOINT: begin
                    r_setpoint <= i_cfg.data[lfps_pkg::LEVEL_W-1:0];
                end
                lfps_pkg::CFG_BASE: begin
                    r_base <= i_cfg.data[lfps_pkg::LEVEL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. Each stage loads when it is empty or when the
    // stage after it is loading, so bubbles collapse under a stalled output.
    // ------------------------------------------------------------------
    logic r_va;
    logic r_vb;
    logic r_vc;
    logic r_vd;
    logic rdy_a;
    logic rdy_b;
    logic rdy_c;
    logic rdy_d;
    logic in_fire;

    assign rdy_d   = !r_vd || o_out.ready;
    assign rdy_c   = !r_vc || rdy_d;
    assign rdy_b   = !r_vb || rdy_c;
    assign rdy_a   = !r_va || rdy_b;
    assign in_fire = i_in.valid && rdy_a;

    assign i_in.ready  = rdy_a;
    assign o_out.valid = r_vd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            if (rdy_a) begin
                r_va <= i_in.valid;
            end
            if (rdy_b) begin
                r_vb <= r_va;
            end
            if (rdy_c) begin
                r_vc <= r_vb;
            end
            if (rdy_d) begin
                r_vd <= r_vc;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage A: error, difference and trapezoid accumulator. The loop state
    // (previous error and saturating sum) is updated on each accepted beat.
    // ------------------------------------------------------------------
    localparam int SUM_EXT_W = lfps_pkg::SUM_WIDTH + 1;

    logic signed [lfps_pkg::ERR_W-1:0]       r_prev_err;
    logic signed [lfps_pkg::SUM_WIDTH-1:0]   r_err_sum;
    logic signed [lfps_pkg::ERR_W-1:0]       n_err;
    logic signed [lfps_pkg::DELTA_W-1:0]     n_delta;
    logic signed [lfps_pkg::DELTA_W-1:0]     n_trap;
    logic signed [SUM_EXT_W-1:0]             n_sum_ext;
    logic signed [lfps_pkg::SUM_WIDTH-1:0]   n_sum;

    logic signed [lfps_pkg::ERR_W-1:0]       r_a_err;
    logic signed [lfps_pkg::DELTA_W-1:0]     r_a_delta;
    logic signed [lfps_pkg::SUM_WIDTH-1:0]   r_a_sum;
    logic                                    r_a_right;

    always_comb begin
        n_err   = lfps_pkg::ERR_W'({1'b0, r_setpoint}) -
                  lfps_pkg::ERR_W'({1'b0, i_in.brightness});
        n_delta = {n_err[lfps_pkg::ERR_W-1], n_err} -
                  {r_prev_err[lfps_pkg::ERR_W-1], r_prev_err};
        n_trap  = {n_err[lfps_pkg::ERR_W-1], n_err} +
                  {r_prev_err[lfps_pkg::ERR_W-1], r_prev_err};
        n_sum_ext = {r_err_sum[lfps_pkg::SUM_WIDTH-1], r_err_sum} +
                    {{(SUM_EXT_W - lfps_pkg::DELTA_W){n_trap[lfps_pkg::DELTA_W-1]}},
                     n_trap};
        // Saturate when the extended sum leaves the signed accumulator range.
        if (n_sum_ext[SUM_EXT_W-1] != n_sum_ext[SUM_EXT_W-2]) begin
            n_sum = n_sum_ext[SUM_EXT_W-1] ?
                    {1'b1, {(lfps_pkg::SUM_WIDTH-1){1'b0}}} :
                    {1'b0, {(lfps_pkg::SUM_WIDTH-1){1'b1}}};
        end else begin
            n_sum = n_sum_ext[lfps_pkg::SUM_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err <= '0;
            r_err_sum  <= '0;
        end else if (in_fire) begin
            r_prev_err <= n_err;
            r_err_sum  <= n_sum;
        end
    end

    // The error is below the setpoint exactly when the sample is nonzero;
    // that steers the correction to the right motor.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_a_err   <= n_err;
            r_a_delta <= n_delta;
            r_a_sum   <= n_sum;
            r_a_right <= (i_in.brightness != '0);
        end
    end

    // ------------------------------------------------------------------
    // Stage B: the three gain products, each one signed multiply.
    // ------------------------------------------------------------------
    logic signed [lfps_pkg::PKP_W-1:0] n_b_kp;
    logic signed [lfps_pkg::PKI_W-1:0] n_b_ki;
    logic signed [lfps_pkg::PKD_W-1:0] n_b_kd;
    logic signed [lfps_pkg::PKP_W-1:0] r_b_kp;
    logic signed [lfps_pkg::PKI_W-1:0] r_b_ki;
    logic signed [lfps_pkg::PKD_W-1:0] r_b_kd;
    logic                              r_b_right;

    assign n_b_kp = $signed({1'b0, r_kp_s}) * r_a_err;
    assign n_b_ki = $signed({1'b0, r_ki}) * r_a_sum;
    assign n_b_kd = $signed({1'b0, r_kd_s}) * r_a_delta;

    always_ff @(posedge i_clk) begin
        if (rdy_b) begin
            r_b_kp    <= n_b_kp;
            r_b_ki    <= n_b_ki;
            r_b_kd    <= n_b_kd;
            r_b_right <= r_a_right;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: sum of the terms, split into sign and magnitude, and the
    // magnitude reduced to N / 1024 with saturation well beyond the duty
    // limit. Dividing the magnitude keeps the quotient truncated toward zero.
    // ------------------------------------------------------------------
    logic signed [lfps_pkg::NUM_W-1:0] n_c_num;
    logic        [lfps_pkg::NUM_W-1:0] n_c_mag;
    logic        [lfps_pkg::X_W-1:0]   n_c_x;
    logic        [lfps_pkg::X_W-1:0]   r_c_x;
    logic                              r_c_neg;
    logic                              r_c_right;

    always_comb begin
        n_c_num = lfps_pkg::NUM_W'(r_b_kp) + lfps_pkg::NUM_W'(r_b_ki) +
                  lfps_pkg::NUM_W'(r_b_kd);
        n_c_mag = n_c_num[lfps_pkg::NUM_W-1] ? -n_c_num : n_c_num;
        if (n_c_mag >= lfps_pkg::NUM_W'(lfps_pkg::MAG_LIMIT)) begin
            n_c_x = '1;
        end else begin
            n_c_x = n_c_mag[lfps_pkg::DIV_SHIFT +: lfps_pkg::X_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_c) begin
            r_c_x     <= n_c_x;
            r_c_neg   <= n_c_num[lfps_pkg::NUM_W-1];
            r_c_right <= r_b_right;
        end
    end

    // ------------------------------------------------------------------
    // Stage D: divide by 125 through a reciprocal multiply, restore the
    // sign, add the base duty and saturate both motors.
    // ------------------------------------------------------------------
    function automatic logic signed [lfps_pkg::PWM_W-1:0] duty_clamp(
        input logic signed [lfps_pkg::MOTOR_W-1:0] value
    );
        logic signed [lfps_pkg::MOTOR_W-1:0] lim;
        lim = lfps_pkg::MOTOR_W'(lfps_pkg::DUTY_LIMIT);
        if (value > lim) begin
            return lfps_pkg::PWM_W'(lfps_pkg::DUTY_LIMIT);
        end else if (value < -lim) begin
            return -lfps_pkg::PWM_W'(lfps_pkg::DUTY_LIMIT);
        end
        return value[lfps_pkg::PWM_W-1:0];
    endfunction

    logic        [lfps_pkg::X_W+lfps_pkg::RECIP_W-1:0] n_d_prod;
    logic        [lfps_pkg::Q_W-1:0]                   n_d_q;
    logic signed [lfps_pkg::SPEED_W-1:0]               n_d_speed;
    logic signed [lfps_pkg::MOTOR_W-1:0]               n_d_base;
    logic signed [lfps_pkg::PWM_W-1:0]                 n_d_drive;
    logic signed [lfps_pkg::PWM_W-1:0]                 n_d_plain;
    logic signed [lfps_pkg::PWM_W-1:0]                 r_d_right_pwm;
    logic signed [lfps_pkg::PWM_W-1:0]                 r_d_left_pwm;

    always_comb begin
        n_d_prod  = (lfps_pkg::X_W + lfps_pkg::RECIP_W)'(r_c_x) *
                    (lfps_pkg::X_W + lfps_pkg::RECIP_W)'(lfps_pkg::RECIP_MUL);
        n_d_q     = n_d_prod[lfps_pkg::RECIP_SHIFT +: lfps_pkg::Q_W];
        n_d_speed = r_c_neg ? -$signed({1'b0, n_d_q}) : $signed({1'b0, n_d_q});
        n_d_base  = $signed(lfps_pkg::MOTOR_W'(r_base));
        n_d_drive = duty_clamp(n_d_base +
                               {n_d_speed[lfps_pkg::SPEED_W-1], n_d_speed});
        n_d_plain = duty_clamp(n_d_base);
    end

    always_ff @(posedge i_clk) begin
        if (rdy_d) begin
            r_d_right_pwm <= r_c_right ? n_d_drive : n_d_plain;
            r_d_left_pwm  <= r_c_right ? n_d_plain : n_d_drive;
        end
    end

    assign o_out.right_pwm = r_d_right_pwm;
    assign o_out.left_pwm  = r_d_left_pwm;

endmodule

// ===== design/lfps_checker.sv =====
`include "line_follow_pid_steering_unit_defines.svh"

module lfps_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic signed [lfps_pkg::PWM_W-1:0] i_right_pwm,
    input logic signed [lfps_pkg::PWM_W-1:0] i_left_pwm
);

    localparam logic signed [lfps_pkg::PWM_W-1:0] DUTY_HI =
        lfps_pkg::PWM_W'(lfps_pkg::DUTY_LIMIT);
    localparam logic signed [lfps_pkg::PWM_W-1:0] DUTY_LO =
        -lfps_pkg::PWM_W'(lfps_pkg::DUTY_LIMIT);

    // Saturation must keep every delivered duty inside the motor range.
    `LFPS_ASSERT_SAME(a_right_range, i_clk, i_rst_n, i_out_valid, (i_right_pwm <= DUTY_HI) && (i_right_pwm >= DUTY_LO), "right duty out of range")
    `LFPS_ASSERT_SAME(a_left_range, i_clk, i_rst_n, i_out_valid, (i_left_pwm <= DUTY_HI) && (i_left_pwm >= DUTY_LO), "left duty out of range")

    // A stalled result stays put until it is taken.
    `LFPS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_right_pwm) && $stable(i_left_pwm), "stalled result changed")

    // Reset flushes the pipeline: nothing is offered in the cycle after it.
    `LFPS_ASSERT_NEXT_ALWAYS(a_reset_flush, i_clk, !i_rst_n, !i_out_valid, "result offered after reset")

endmodule

bind line_follow_pid_steering_unit lfps_checker u_lfps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_right_pwm (o_out.right_pwm),
    .i_left_pwm  (o_out.left_pwm)
);
